[design/rts_pkg.sv]
// Package for the reserving task scheduler: table size, operation codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package rts_pkg;

  localparam int NUM_TASKS = 8;
  localparam int TASK_W    = $clog2(NUM_TASKS);
  localparam int IDX_W     = 3;

  // operation codes (s_tuser)
  localparam logic [2:0] OP_SCHED       = 3'd0;
  localparam logic [2:0] OP_SET_EVENT   = 3'd1;
  localparam logic [2:0] OP_SET_LATENCY = 3'd2;
  localparam logic [2:0] OP_SET_RESERVE = 3'd3;
  localparam logic [2:0] OP_SET_NEXT    = 3'd4;

  // configuration register indexes
  localparam logic CFG_IDLE_LIMIT = 1'b0;
  localparam logic CFG_TICK_SHIFT = 1'b1;

  localparam logic [30:0] IDLE_LIMIT_RESET = 31'd60000;
  localparam int          RES_CLK_W        = 8 + 15;

  localparam logic signed [33:0] S32_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] S32_MIN = -34'sh0_8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AGE,
    ST_BLOCK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic age;
    logic block;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic sched_op;
    logic age_last;
    logic block_done;
    logic out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/rts_ctrl.sv]
// Controller state machine of the reserving task scheduler.
// Depends on rts_pkg; drives commands into rts_dp and reads its status.
`default_nettype none

module rts_ctrl import rts_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && status.sched_op) state_next = ST_AGE;
      end
      ST_AGE: begin
        if (status.age_last) state_next = ST_BLOCK;
      end
      ST_BLOCK: begin
        if (status.block_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_AGE:   cmd.age     = 1'b1;
      ST_BLOCK: cmd.block   = 1'b1;
      ST_OUT:   cmd.publish = status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[design/rts_dp.sv]
// Datapath of the reserving task scheduler: task table, config registers,
// scan counter, selection registers and the output beat register.
// Depends on rts_pkg; sequenced by rts_ctrl.
`default_nettype none

module rts_dp import rts_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [30:0] cfg_wdata,
  input  wire logic [79:0] s_tdata,
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,
  output logic             m_tuser
);

  logic [30:0] idle_limit;
  logic [3:0]  tick_shift;

  logic [7:0]         ev  [NUM_TASKS];
  logic [7:0]         lat [NUM_TASKS];
  logic [7:0]         rsv [NUM_TASKS];
  logic signed [31:0] cd  [NUM_TASKS];

  logic [TASK_W-1:0]  cnt;
  logic [TASK_W-1:0]  sel;
  logic               found;
  logic signed [31:0] nxt;
  logic [7:0]         sel_res;
  logic [15:0]        timer;

  logic               out_found;
  logic [IDX_W-1:0]   out_sel;
  logic signed [31:0] out_next;

  // input beat fields
  logic [IDX_W-1:0]   in_idx;
  logic [7:0]         in_event;
  logic [7:0]         in_latency;
  logic [7:0]         in_reserve;
  logic signed [31:0] in_delay;
  logic [15:0]        in_timer;
  logic [TASK_W-1:0]  wr_idx;
  logic               idx_ok;

  assign in_idx     = s_tdata[2:0];
  assign in_event   = s_tdata[10:3];
  assign in_latency = s_tdata[18:11];
  assign in_reserve = s_tdata[26:19];
  assign in_delay   = s_tdata[58:27];
  assign in_timer   = s_tdata[74:59];
  assign wr_idx     = TASK_W'(in_idx);
  assign idx_ok     = 32'(in_idx) < NUM_TASKS;

  // current scan entry
  logic signed [31:0]       aged;
  logic                     cur_active;
  logic [RES_CLK_W-1:0]     res_clk;
  logic                     hit;

  assign aged       = sat32(34'(cd[cnt]) - $signed({18'd0, timer}));
  assign cur_active = ev[cnt] != 8'd0;
  assign res_clk    = RES_CLK_W'(sel_res) << tick_shift;
  assign hit        = cur_active &&
                      ((lat[cnt] < sel_res) ||
                       (cd[cnt] < $signed({{(32 - RES_CLK_W){1'b0}}, res_clk})));

  assign status.sched_op   = s_tuser == OP_SCHED;
  assign status.age_last   = cnt == '0;
  assign status.block_done = !found || (cnt == sel) || hit;
  assign status.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= IDLE_LIMIT_RESET;
      tick_shift <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_IDLE_LIMIT: idle_limit <= cfg_wdata;
        CFG_TICK_SHIFT: tick_shift <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        ev[i]  <= '0;
        lat[i] <= '0;
        rsv[i] <= '0;
        cd[i]  <= '0;
      end
    end else if (cmd.accept && idx_ok) begin
      case (s_tuser)
        OP_SET_EVENT:   ev[wr_idx]  <= in_event;
        OP_SET_LATENCY: lat[wr_idx] <= in_latency;
        OP_SET_RESERVE: rsv[wr_idx] <= in_reserve;
        OP_SET_NEXT:    cd[wr_idx]  <= sat32(34'(in_delay) + $signed({18'd0, in_timer}));
        default: ;
      endcase
    end else if (cmd.age) begin
      cd[cnt] <= aged;
    end
  end

  // scan and selection
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cnt     <= TASK_W'(NUM_TASKS - 1);
      timer   <= in_timer;
      nxt     <= $signed({1'b0, idle_limit});
      sel     <= '0;
      sel_res <= '0;
    end else if (cmd.age) begin
      if (ev[cnt] != 8'd0) begin
        if (aged <= nxt) begin
          nxt     <= aged;
          sel     <= cnt;
          sel_res <= rsv[cnt];
        end else if (aged <= 32'sd0) begin
          sel     <= cnt;
          sel_res <= rsv[cnt];
        end
      end
      if (cnt != '0) cnt <= cnt - 1'b1;
    end else if (cmd.block) begin
      if (found && (cnt != sel) && hit) begin
        sel <= cnt;
        nxt <= cd[cnt];
      end
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.accept) begin
      found <= 1'b0;
    end else if (cmd.age && (ev[cnt] != 8'd0) && ((aged <= nxt) || (aged <= 32'sd0))) begin
      found <= 1'b1;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.publish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_found <= found;
      out_sel   <= found ? IDX_W'(sel) : '0;
      out_next  <= nxt;
    end
  end

  assign m_tdata = {5'd0, out_next, out_sel};
  assign m_tuser = out_found;

endmodule

`default_nettype wire

[design/reserving_task_scheduler_unit.sv]
// Reserving task scheduler, top level: stream ports, config write port,
// controller (rts_ctrl) and datapath (rts_dp). Depends on rts_pkg.
//
// Write operations (set event, latency, reserve, next delay) complete in the
// cycle their beat is taken and return nothing. A schedule beat walks the
// eight-entry task table twice through one entry port: an aging pass from the
// top index down and a blocking pass from index 0 up to the chosen task, then
// loads the result register, waiting for it to free.
// Only one item is in flight; s_tready is high while the scheduler is idle.
`default_nettype none

module reserving_task_scheduler_unit import rts_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [30:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [2:0] task slot, [10:3] event_code, [18:11] latency_value,
  // [26:19] reserve_value, [58:27] delay_clocks, [74:59] timer_now, rest zero
  input  wire logic [79:0] s_tdata,
  // [2:0] operation
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] selected_task, [34:3] next_event_clocks, rest zero
  output logic [39:0]      m_tdata,
  // [0] task_found
  output logic             m_tuser
);

  cmd_t    cmd;
  status_t status;

  rts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

`default_nettype wire

[bench/tb_reserving_task_scheduler_unit.sv]
// Testbench for reserving_task_scheduler_unit: directed and random table writes and
// schedule beats, checked against a predictor of the table, aging and blocking rules.
// Depends on rts_pkg and the design files.
`default_nettype none

module tb_reserving_task_scheduler_unit;
  import rts_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 20;

  typedef struct {
    logic [2:0]  op;
    logic [2:0]  idx;
    logic [7:0]  ev;
    logic [7:0]  lat;
    logic [7:0]  rsv;
    logic [31:0] delay;
    logic [15:0] timer;
  } sched_cmd_t;

  typedef struct {
    logic               found;
    logic [2:0]         sel;
    logic signed [31:0] next_evt;
  } sched_result_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_addr  = CFG_IDLE_LIMIT;
  logic [30:0] cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata   = '0;
  logic [2:0]  s_tuser   = OP_SCHED;
  logic        m_tvalid;
  logic        m_tready  = 1'b1;
  logic [39:0] m_tdata;
  logic        m_tuser;

  reserving_task_scheduler_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // predicted scheduler state
  logic [7:0]         pred_event     [NUM_TASKS];
  logic [7:0]         task_latency   [NUM_TASKS];
  logic [7:0]         task_reserve   [NUM_TASKS];
  logic signed [31:0] task_countdown [NUM_TASKS];
  logic [30:0]        idle_limit;
  logic [3:0]         tick_shift;

  sched_result_t expected_picks[$];
  int            mismatches   = 0;
  int            quiet_cycles = 0;
  int unsigned   rx_hold      = 0;
  bit            no_idle      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pause_len();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic signed [31:0] clamp_s32(longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(64'h8000_0000)) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < NUM_TASKS; i++) begin
      pred_event[i]     = '0;
      task_latency[i]   = '0;
      task_reserve[i]   = '0;
      task_countdown[i] = '0;
    end
    idle_limit = IDLE_LIMIT_RESET;
    tick_shift = '0;
  endfunction

  // applies one accepted beat to the table; a schedule queues its predicted pick
  function automatic void apply_beat(sched_cmd_t c);
    longint        nxt;
    longint        res_clk;
    int            pick;
    logic [7:0]    res_ticks;
    sched_result_t r;
    case (c.op)
      OP_SET_EVENT:   pred_event[c.idx]   = c.ev;
      OP_SET_LATENCY: task_latency[c.idx] = c.lat;
      OP_SET_RESERVE: task_reserve[c.idx] = c.rsv;
      OP_SET_NEXT: begin
        task_countdown[c.idx] = clamp_s32(longint'($signed(c.delay)) + longint'(c.timer));
      end
      OP_SCHED: begin
        nxt  = longint'(idle_limit);
        pick = -1;
        for (int i = NUM_TASKS - 1; i >= 0; i--) begin
          task_countdown[i] = clamp_s32(longint'(task_countdown[i]) - longint'(c.timer));
          if (pred_event[i] != 0) begin
            if (longint'(task_countdown[i]) <= nxt) begin
              nxt  = task_countdown[i];
              pick = i;
            end else if (task_countdown[i] <= 0) begin
              pick = i;
            end
          end
        end
        if (pick >= 0) begin
          res_ticks = task_reserve[pick];
          res_clk   = longint'(res_ticks) << tick_shift;
          for (int i = 0; i < pick; i++) begin
            if (pred_event[i] != 0 &&
                (task_latency[i] < res_ticks || longint'(task_countdown[i]) < res_clk)) begin
              nxt  = task_countdown[i];
              pick = i;
              break;
            end
          end
        end
        r.found    = (pick >= 0);
        r.sel      = r.found ? 3'(pick) : 3'd0;
        r.next_evt = nxt[31:0];
        expected_picks.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d at %0t: %s expected %0d got %0d", mismatches, $realtime,
               what, want, got);
  endtask

  task automatic send_beat(input sched_cmd_t c);
    int unsigned gap;
    gap = pause_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.op;
    s_tdata  <= {5'b0, c.timer, c.delay, c.rsv, c.lat, c.ev, c.idx};
    do @(posedge clk); while (!s_tready);
    apply_beat(c);
  endtask

  task automatic issue(input logic [2:0] op, input logic [2:0] idx, input logic [7:0] val,
                       input logic [31:0] delay, input logic [15:0] timer);
    sched_cmd_t c;
    c.op    = op;
    c.idx   = idx;
    c.ev    = val;
    c.lat   = val;
    c.rsv   = val;
    c.delay = delay;
    c.timer = timer;
    send_beat(c);
  endtask

  // hold off the sender until every pending pick has come back and the unit is idle
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic addr, input logic [30:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    if (addr == CFG_IDLE_LIMIT) idle_limit = data;
    else tick_shift = data[3:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sched_cmd_t random_cmd();
    sched_cmd_t  c;
    int unsigned r;
    r       = $urandom_range(0, 99);
    c.idx   = 3'($urandom_range(0, 7));
    c.ev    = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    c.lat   = 8'($urandom_range(0, 255));
    c.rsv   = 8'($urandom_range(0, 255));
    if (r < 30)      c.op = OP_SCHED;
    else if (r < 42) c.op = OP_SET_EVENT;
    else if (r < 52) c.op = OP_SET_LATENCY;
    else if (r < 62) c.op = OP_SET_RESERVE;
    else if (r < 97) c.op = OP_SET_NEXT;
    else             c.op = 3'($urandom_range(OP_SET_NEXT + 1, 7));
    case ($urandom_range(0, 9))
      0:       c.delay = $urandom();
      1:       c.delay = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2:       c.delay = -$urandom_range(0, 2000);
      default: c.delay = $urandom_range(0, 70000);
    endcase
    case ($urandom_range(0, 7))
      0:       c.timer = 16'($urandom_range(0, 65535));
      1:       c.timer = '0;
      default: c.timer = 16'($urandom_range(0, 300));
    endcase
    return c;
  endfunction

  always @(posedge clk) begin : check_beat
    sched_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_picks.size() == 0) begin
        flag_mismatch("result with nothing pending", 0, $signed(m_tdata[34:3]));
      end else begin
        want = expected_picks.pop_front();
        if (m_tuser !== want.found) flag_mismatch("task_found", want.found, m_tuser);
        if (m_tdata[2:0] !== want.sel) flag_mismatch("selected_task", want.sel, m_tdata[2:0]);
        if (m_tdata[34:3] !== want.next_evt)
          flag_mismatch("next_event_clocks", want.next_evt, $signed(m_tdata[34:3]));
      end
    end
  end

  always @(posedge clk) begin : rx_stall
    int unsigned draw;
    if (m_tvalid && m_tready) begin
      draw = pause_len();
      rx_hold <= draw;
      if (draw != 0) m_tready <= 1'b0;
    end else if (!m_tready) begin
      if (rx_hold == 0) m_tready <= 1'b1;
      else if (m_tvalid || $urandom_range(0, 1)) rx_hold <= rx_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_after_reset();
    issue(OP_SCHED, 3'd0, 8'd0, 32'd0, 16'd0);
    for (int u = OP_SET_NEXT + 1; u < 8; u++) issue(3'(u), 3'd7, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    issue(OP_SCHED, 3'd7, 8'hFF, 32'd0, 16'hFFFF);
  endtask

  task automatic test_selection_rules();
    // saturation both ways, active but not due
    issue(OP_SET_EVENT, 3'd7, 8'd255, 32'd0, 16'd0);
    issue(OP_SET_NEXT, 3'd7, 8'd0, 32'h7FFF_FFFF, 16'hFFFF);
    issue(OP_SCHED, 3'd0, 8'd0, 32'd0, 16'd0);
    issue(OP_SET_NEXT, 3'd7, 8'd0, 32'h8000_0000, 16'd0);
    issue(OP_SCHED, 3'd0, 8'd0, 32'd0, 16'hFFFF);
    issue(OP_SET_EVENT, 3'd7, 8'd0, 32'd0, 16'd0);
    // tie: lower index wins
    issue(OP_SET_EVENT, 3'd5, 8'd1, 32'd0, 16'd0);
    issue(OP_SET_NEXT, 3'd5, 8'd0, 32'd100, 16'd0);
    issue(OP_SET_EVENT, 3'd3, 8'd1, 32'd0, 16'd0);
    issue(OP_SET_NEXT, 3'd3, 8'd0, 32'd60, 16'd40);
    issue(OP_SCHED, 3'd0, 8'd0, 32'd0, 16'd0);
    // overdue task takes over without moving the next event time
    issue(OP_SET_EVENT, 3'd6, 8'd2, 32'd0, 16'd0);
    issue(OP_SET_NEXT, 3'd6, 8'd0, -32'sd5, 16'd0);
    issue(OP_SET_EVENT, 3'd2, 8'd9, 32'd0, 16'd0);
    issue(OP_SET_NEXT, 3'd2, 8'd0, -32'sd1, 16'd0);
    issue(OP_SCHED, 3'd0, 8'd0, 32'd0, 16'd0);
    // blocking by latency, then by countdown against reserve
    issue(OP_SET_RESERVE, 3'd2, 8'd10, 32'd0, 16'd0);
    issue(OP_SET_EVENT, 3'd1, 8'd4, 32'd0, 16'd0);
    issue(OP_SET_LATENCY, 3'd1, 8'd3, 32'd0, 16'd0);
    issue(OP_SET_NEXT, 3'd1, 8'd0, 32'd50000, 16'd0);
    issue(OP_SCHED, 3'd0, 8'd0, 32'd0, 16'd0);
    issue(OP_SET_LATENCY, 3'd1, 8'd255, 32'd0, 16'd0);
    issue(OP_SET_NEXT, 3'd1, 8'd0, 32'd5, 16'd0);
    issue(OP_SCHED, 3'd0, 8'd0, 32'd0, 16'd0);
    issue(OP_SET_RESERVE, 3'd1, 8'd0, 32'd0, 16'd0);
  endtask

  task automatic test_config_extremes();
    for (int k = 0; k < 4; k++) begin
      settle();
      case (k)
        0: begin write_cfg(CFG_IDLE_LIMIT, 31'd0);            write_cfg(CFG_TICK_SHIFT, 31'd15); end
        1: begin write_cfg(CFG_IDLE_LIMIT, 31'h7FFF_FFFF);    write_cfg(CFG_TICK_SHIFT, 31'd0);  end
        2: begin write_cfg(CFG_IDLE_LIMIT, 31'h5555_5555);    write_cfg(CFG_TICK_SHIFT, 31'd10); end
        default: begin
          write_cfg(CFG_IDLE_LIMIT, 31'h2AAA_AAAA);
          write_cfg(CFG_TICK_SHIFT, 31'd5);
        end
      endcase
      repeat (30) send_beat(random_cmd());
    end
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 1000; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n % 250 == 0) begin
        settle();
        write_cfg(CFG_IDLE_LIMIT, $urandom_range(0, 1) ? 31'($urandom_range(0, 100000))
                                                       : 31'($urandom()));
        write_cfg(CFG_TICK_SHIFT, 31'($urandom_range(0, 15)));
      end else if ($urandom_range(0, 59) == 0) begin
        settle();
      end
      send_beat(random_cmd());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_table();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_selection_rules();
    test_config_extremes();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[reserving_task_scheduler_unit.f]
design/rts_pkg.sv
design/rts_ctrl.sv
design/rts_dp.sv
design/reserving_task_scheduler_unit.sv
bench/tb_reserving_task_scheduler_unit.sv
